FILE: rtl/core/shtoa_pkg.sv
// Package: shared types and constants for the string hash table.
`timescale 1ns / 1ps
package shtoa_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int MAX_LEN_DEF   = 29;
    localparam int TABLE_SIZE_W  = 11;
    localparam int STATUS_W      = 3;
    localparam int SLOT_W        = 10;
    localparam int PROBE_W       = 11;
    localparam int MOD_STEPS     = 4;
    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST = 11'd1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_H_MUL,
        S_H_ADD,
        S_H_MOD,
        S_LEN_RD,
        S_LEN_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_WR_CH,
        S_FINISH
    } state_t;

endpackage

FILE: rtl/core/string_hash_table_open_addressing.sv
// Top level: byte-streamed word hash table with open addressing and a shared modulo unit.
`timescale 1ns / 1ps
// Words arrive one byte per input word; the byte with tlast set starts an insert (tuser 0) or a
// lookup (tuser 1). Non-final bytes are buffered and the block stays ready for the next one. A
// final byte runs a probe sequence: each probe rehashes the buffered word byte by byte with one
// shared 4-bit-per-cycle remainder unit, then reads the slot length, and a lookup compares the
// stored word byte by byte while an insert writes it byte by byte. After reset the block clears
// every slot length entry before it accepts any byte. Words longer than MAX_LEN answer "too
// long" at once. Results leave through an output register.
module string_hash_table_open_addressing
    import shtoa_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int MAX_LEN  = MAX_LEN_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [TABLE_SIZE_W-1:0]   cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // key_byte
    input  logic                      s_tuser,   // mode
    input  logic                      s_tlast,   // last_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata    // status[2:0], slot[12:3], probe_count[23:13]
);

    localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CntW  = ($clog2(CAPACITY + 1) > TABLE_SIZE_W) ?
                           $clog2(CAPACITY + 1) : TABLE_SIZE_W;
    localparam int TW    = CntW + 1;
    localparam int LenW  = $clog2(MAX_LEN + 1);
    localparam int IdxW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int ChD   = CAPACITY * MAX_LEN;
    localparam int ChW   = $clog2(ChD);
    localparam int ModW  = $clog2(32 / MOD_STEPS);
    localparam logic [ModW-1:0] ModLast = ModW'(32 / MOD_STEPS - 1);

    state_t state_reg, state_next;

    logic [TABLE_SIZE_W-1:0] tsize_reg;
    logic [CntW-1:0]  size_reg, size_next;
    logic [7:0]       buf_reg [MAX_LEN];
    logic [LenW-1:0]  wlen_reg, wlen_next;
    logic             over_reg, over_next;
    logic             mode_reg, mode_next;
    logic [CntW-1:0]  k_reg, k_next;
    logic [IdxW-1:0]  idx_reg, idx_next;
    logic [31:0]      pw_reg, pw_next;
    logic [31:0]      term_reg, term_next;
    logic [31:0]      sum_reg, sum_next;
    logic [AddrW-1:0] a_reg, a_next;
    logic [ModW-1:0]  mcnt_reg, mcnt_next;
    logic [AddrW-1:0] slot_reg, slot_next;
    logic [ChW-1:0]   base_reg, base_next;
    logic [AddrW-1:0] clr_reg, clr_next;

    logic             mv_reg, mv_next;
    logic [STATUS_W-1:0] ost_reg, ost_next;
    logic [SLOT_W-1:0]   oslot_reg, oslot_next;
    logic [PROBE_W-1:0]  oprb_reg, oprb_next;
    logic [STATUS_W-1:0] pst_reg, pst_next;
    logic [SLOT_W-1:0]   pslot_reg, pslot_next;
    logic [PROBE_W-1:0]  pprb_reg, pprb_next;

    logic [LenW-1:0]  len_mem [CAPACITY];
    logic [LenW-1:0]  len_q;
    logic             len_we;
    logic [AddrW-1:0] len_waddr;
    logic [LenW-1:0]  len_wdata;

    logic [7:0]       ch_mem [ChD];
    logic [7:0]       ch_q;
    logic             ch_we;
    logic [ChW-1:0]   ch_addr;

    logic             s_acc;
    logic [7:0]       buf_rd;
    logic             idx_end;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {oprb_reg, oslot_reg, ost_reg};
    assign buf_rd   = buf_reg[idx_reg];
    assign idx_end  = (LenW'(idx_reg) + LenW'(1)) == wlen_reg;
    assign ch_addr  = base_reg + ChW'(idx_reg);

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_q <= len_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (ch_we) begin
            ch_mem[ch_addr] <= buf_rd;
        end
        ch_q <= ch_mem[ch_addr];
    end

    always_ff @(posedge aclk) begin
        if (s_acc && (wlen_reg < LenW'(MAX_LEN))) begin
            buf_reg[wlen_reg[IdxW-1:0]] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            tsize_reg <= TABLE_SIZE_RST;
            wlen_reg  <= '0;
            over_reg  <= 1'b0;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                tsize_reg <= cfg_wdata;
            end
            wlen_reg  <= wlen_next;
            over_reg  <= over_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg  <= size_next;
        mode_reg  <= mode_next;
        k_reg     <= k_next;
        idx_reg   <= idx_next;
        pw_reg    <= pw_next;
        term_reg  <= term_next;
        sum_reg   <= sum_next;
        a_reg     <= a_next;
        mcnt_reg  <= mcnt_next;
        slot_reg  <= slot_next;
        base_reg  <= base_next;
        ost_reg   <= ost_next;
        oslot_reg <= oslot_next;
        oprb_reg  <= oprb_next;
        pst_reg   <= pst_next;
        pslot_reg <= pslot_next;
        pprb_reg  <= pprb_next;
    end

    always_comb begin
        logic [TW-1:0]    trial;
        logic [AddrW-1:0] rem;
        logic [31:0]      sh;
        logic             next_probe;
        logic [CntW-1:0]  k_inc;

        state_next = state_reg;
        size_next  = size_reg;
        wlen_next  = wlen_reg;
        over_next  = over_reg;
        mode_next  = mode_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        pw_next    = pw_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        a_next     = a_reg;
        mcnt_next  = mcnt_reg;
        slot_next  = slot_reg;
        base_next  = base_reg;
        clr_next   = clr_reg;
        mv_next    = mv_reg && !m_tready;
        ost_next   = ost_reg;
        oslot_next = oslot_reg;
        oprb_next  = oprb_reg;
        pst_next   = pst_reg;
        pslot_next = pslot_reg;
        pprb_next  = pprb_reg;
        len_we     = 1'b0;
        len_waddr  = slot_reg;
        len_wdata  = wlen_reg;
        ch_we      = 1'b0;
        next_probe = 1'b0;
        k_inc      = k_reg + CntW'(1);
        rem        = a_reg;
        sh         = sum_reg;
        trial      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                len_we    = 1'b1;
                len_waddr = clr_reg;
                len_wdata = '0;
                clr_next  = clr_reg + AddrW'(1);
                if (clr_reg == AddrW'(CAPACITY - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    if (wlen_reg < LenW'(MAX_LEN)) begin
                        wlen_next = wlen_reg + LenW'(1);
                    end else begin
                        over_next = 1'b1;
                    end
                    mode_next = s_tuser;
                    if (s_tlast) begin
                        if (over_reg || (wlen_reg == LenW'(MAX_LEN))) begin
                            pst_next   = ST_TOO_LONG;
                            pslot_next = '0;
                            pprb_next  = '0;
                            state_next = S_FINISH;
                        end else begin
                            if (tsize_reg == '0) begin
                                size_next = CntW'(1);
                            end else if (CntW'(tsize_reg) > CntW'(CAPACITY)) begin
                                size_next = CntW'(CAPACITY);
                            end else begin
                                size_next = CntW'(tsize_reg);
                            end
                            k_next     = '0;
                            idx_next   = '0;
                            a_next     = '0;
                            pw_next    = 32'd1;
                            state_next = S_H_MUL;
                        end
                    end
                end
            end
            S_H_MUL: begin
                term_next  = 32'({24'd0, buf_rd} * (pw_reg + {pw_reg[15:0], 16'd0}));
                state_next = S_H_ADD;
            end
            S_H_ADD: begin
                sum_next   = 32'(a_reg) + term_reg + 32'(k_reg);
                rem        = '0;
                a_next     = '0;
                mcnt_next  = '0;
                state_next = S_H_MOD;
            end
            S_H_MOD: begin
                for (int b = 0; b < MOD_STEPS; b++) begin
                    trial = TW'({rem, sh[31]});
                    sh    = {sh[30:0], 1'b0};
                    if (trial >= TW'(size_reg)) begin
                        rem = AddrW'(trial - TW'(size_reg));
                    end else begin
                        rem = AddrW'(trial);
                    end
                end
                a_next    = rem;
                sum_next  = sh;
                mcnt_next = mcnt_reg + ModW'(1);
                if (mcnt_reg == ModLast) begin
                    pw_next = pw_reg + {pw_reg[23:0], 8'd0};
                    if (idx_end) begin
                        slot_next  = rem;
                        state_next = S_LEN_RD;
                    end else begin
                        idx_next   = idx_reg + IdxW'(1);
                        state_next = S_H_MUL;
                    end
                end
            end
            S_LEN_RD: begin
                base_next  = ChW'(slot_reg * ChW'(MAX_LEN));
                state_next = S_LEN_CHK;
            end
            S_LEN_CHK: begin
                idx_next = '0;
                if (len_q == '0) begin
                    if (!mode_reg) begin
                        state_next = S_WR_CH;
                    end else begin
                        pst_next   = ST_NOT_FOUND;
                        pslot_next = '0;
                        pprb_next  = PROBE_W'(k_reg);
                        state_next = S_FINISH;
                    end
                end else if (mode_reg && (len_q == wlen_reg)) begin
                    state_next = S_CMP_RD;
                end else begin
                    next_probe = 1'b1;
                end
            end
            S_CMP_RD: begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                if (ch_q != buf_rd) begin
                    next_probe = 1'b1;
                end else if (idx_end) begin
                    pst_next   = ST_FOUND;
                    pslot_next = SLOT_W'(slot_reg);
                    pprb_next  = PROBE_W'(k_reg);
                    state_next = S_FINISH;
                end else begin
                    idx_next   = idx_reg + IdxW'(1);
                    state_next = S_CMP_RD;
                end
            end
            S_WR_CH: begin
                ch_we    = 1'b1;
                idx_next = idx_reg + IdxW'(1);
                if (idx_end) begin
                    len_we     = 1'b1;
                    pst_next   = ST_INSERTED;
                    pslot_next = SLOT_W'(slot_reg);
                    pprb_next  = PROBE_W'(k_reg);
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    ost_next   = pst_reg;
                    oslot_next = pslot_reg;
                    oprb_next  = pprb_reg;
                    wlen_next  = '0;
                    over_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (next_probe) begin
            if (k_inc == size_reg) begin
                pst_next   = mode_reg ? ST_NOT_FOUND : ST_FULL;
                pslot_next = '0;
                pprb_next  = PROBE_W'(k_reg);
                state_next = S_FINISH;
            end else begin
                k_next     = k_inc;
                idx_next   = '0;
                a_next     = '0;
                pw_next    = 32'd1;
                state_next = S_H_MUL;
            end
        end
    end

`ifndef SYNTHESIS
    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LEN_CHK) |-> (CntW'(slot_reg) < size_reg))
        else $error("probe slot outside table");
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LEN_CHK) |-> (k_reg < size_reg))
        else $error("probe count beyond table size");
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wlen_reg <= LenW'(MAX_LEN))
        else $error("word length overflow");
    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && (!mv_reg || m_tready)) |=> (m_tvalid && s_tready))
        else $error("result not presented");
`endif

endmodule

FILE: sim/string_hash_table_open_addressing_tb.sv
// Testbench: streams words into the hash table and checks each insert/lookup result.
`timescale 1ns / 1ps
module string_hash_table_open_addressing_tb;
    import shtoa_pkg::*;

    localparam int SLOTS     = 1024;
    localparam int WORD_MAX  = 29;
    localparam int CYCLE_CAP = 3000000;

    typedef struct packed {
        logic       mode;
        logic [7:0] key;
        logic       last;
    } key_byte_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [PROBE_W-1:0]   probes;
    } lookup_res_t;

    typedef struct packed {
        logic [WORD_MAX*8-1:0] ch;
        int                    n;
    } word_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_we;
    logic [TABLE_SIZE_W-1:0] cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [7:0]              s_tdata;   // key_byte
    logic                    s_tuser;   // mode
    logic                    s_tlast;   // last_byte
    logic                    m_tvalid;
    logic                    m_tready;
    logic [23:0]             m_tdata;   // status[2:0], slot[12:3], probe_count[23:13]

    key_byte_t   byte_q[$];
    lookup_res_t pending_res[$];
    word_t       stored_words[$];

    logic [TABLE_SIZE_W-1:0] tbl_size;
    logic [7:0]              buf_ch[WORD_MAX];
    int                      buf_len;
    logic                    buf_overlong;
    logic [7:0]              slot_ch[SLOTS][WORD_MAX];
    int                      slot_len[SLOTS];

    int send_idle;
    int recv_stall;
    int stretch_req;
    int stretch_seen;
    int stretch_left;
    int errors = 0;
    int cycles = 0;

    string_hash_table_open_addressing i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] probe_hash(int k, logic [31:0] size);
        logic [31:0] a;
        logic [31:0] pw;
        logic [31:0] sum;
        a  = 0;
        pw = 1;
        for (int i = 0; i < buf_len; i++) begin
            sum = a + {24'd0, buf_ch[i]} * pw * 32'd65537 + k;
            a   = sum % size;
            pw  = pw * 32'd257;
        end
        return a;
    endfunction

    function automatic logic slot_holds_word(int s);
        if (slot_len[s] != buf_len) return 1'b0;
        for (int i = 0; i < buf_len; i++)
            if (slot_ch[s][i] != buf_ch[i]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic hash_table_step(key_byte_t kb);
        lookup_res_t r;
        logic [31:0] size;
        logic [31:0] s;
        logic        done;
        if (buf_len < WORD_MAX) begin
            buf_ch[buf_len] = kb.key;
            buf_len++;
        end else begin
            buf_overlong = 1'b1;
        end
        if (kb.last) begin
            r = '{ST_INSERTED, '0, '0};
            done = 1'b0;
            if (buf_overlong) begin
                r.status = ST_TOO_LONG;
            end else begin
                size = (tbl_size == 0) ? 1 : (tbl_size > SLOTS) ? SLOTS : tbl_size;
                for (int k = 0; k < size && !done; k++) begin
                    s = probe_hash(k, size);
                    if (slot_len[s] == 0) begin
                        if (!kb.mode) begin
                            for (int i = 0; i < buf_len; i++) slot_ch[s][i] = buf_ch[i];
                            slot_len[s] = buf_len;
                            r.status = ST_INSERTED;
                            r.slot   = s[SLOT_W-1:0];
                        end else begin
                            r.status = ST_NOT_FOUND;
                        end
                        r.probes = k[PROBE_W-1:0];
                        done = 1'b1;
                    end else if (kb.mode && slot_holds_word(s)) begin
                        r.status = ST_FOUND;
                        r.slot   = s[SLOT_W-1:0];
                        r.probes = k[PROBE_W-1:0];
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    r.status = kb.mode ? ST_NOT_FOUND : ST_FULL;
                    r.slot   = '0;
                    r.probes = PROBE_W'(size - 1);
                end
            end
            buf_len = 0;
            buf_overlong = 1'b0;
            pending_res.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            tbl_size = TABLE_SIZE_RST;
            buf_len = 0;
            buf_overlong = 1'b0;
            for (int i = 0; i < SLOTS; i++) slot_len[i] = 0;
        end else begin
            if (cfg_we) tbl_size = cfg_wdata;
            if (s_tvalid && s_tready) hash_table_step('{s_tuser, s_tdata, s_tlast});
        end
    end

    always @(posedge aclk) begin
        key_byte_t kb;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                kb = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= kb.mode;
                s_tdata  <= kb.key;
                s_tlast  <= kb.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            stretch_seen <= 0;
            stretch_left <= 0;
        end else if (stretch_left != 0) begin
            m_tready     <= 1'b0;
            stretch_left <= stretch_left - 1;
        end else if (stretch_req != stretch_seen) begin
            m_tready     <= 1'b0;
            stretch_seen <= stretch_req;
            stretch_left <= 3000;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        lookup_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_res.pop_front();
                if (m_tdata[2:0] != want.status || m_tdata[12:3] != want.slot
                        || m_tdata[23:13] != want.probes) begin
                    $display("%0t: expected status %0d slot %0d probes %0d, actual %0d %0d %0d",
                             $time, want.status, want.slot, want.probes,
                             m_tdata[2:0], m_tdata[12:3], m_tdata[23:13]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("string_hash_table_open_addressing_tb: errors");
            $finish;
        end
    end

    task automatic push_word(logic mode, word_t w, int extra);
        for (int i = 0; i < w.n + extra; i++)
            byte_q.push_back('{mode, (i < w.n) ? w.ch[i*8 +: 8] : 8'h5a,
                               i == w.n + extra - 1});
    endtask

    function automatic word_t rand_word(int n);
        word_t w;
        w.ch = '0;
        w.n  = n;
        for (int i = 0; i < n; i++)
            w.ch[i*8 +: 8] = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(97, 100));
        return w;
    endfunction

    task automatic settle();
        wait (byte_q.size() == 0);
        @(posedge aclk);
        while (s_tvalid) @(posedge aclk);
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_table_size(logic [TABLE_SIZE_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(int n_items, int s_idle, int r_stall, int tsize);
        word_t w;
        int    len;
        int    extra;
        logic  mode;
        send_idle  = s_idle;
        recv_stall = r_stall;
        set_table_size(TABLE_SIZE_W'(tsize));
        while (n_items > 0) begin
            extra = 0;
            case ($urandom_range(19))
                0:       len = WORD_MAX;
                1: begin len = WORD_MAX; extra = $urandom_range(1, 3); end
                default: len = $urandom_range(1, 4);
            endcase
            mode = $urandom_range(1);
            if (mode && stored_words.size() != 0 && $urandom_range(1))
                w = stored_words[$urandom_range(stored_words.size() - 1)];
            else
                w = rand_word(len);
            if (!mode && extra == 0) stored_words.push_back(w);
            push_word(mode, w, extra);
            n_items -= w.n + extra;
        end
        settle();
    endtask

    initial begin
        word_t w;
        stretch_req  = 0;
        send_idle    = 0;
        recv_stall   = 0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: tiny table fills, lookups hit and miss, byte extremes, length limits
        set_table_size(TABLE_SIZE_W'(3));
        w = rand_word(1);
        w.ch[7:0] = 8'h00;
        repeat (4) push_word(1'b0, w, 0);
        push_word(1'b1, w, 0);
        w.ch[7:0] = 8'hff;
        push_word(1'b1, w, 0);
        push_word(1'b0, rand_word(WORD_MAX), 0);
        push_word(1'b0, rand_word(WORD_MAX), 1);
        settle();
        set_table_size(TABLE_SIZE_W'(1));
        w.ch[7:0] = 8'hff;
        push_word(1'b1, w, 0);
        push_word(1'b0, w, 0);
        settle();

        random_phase(445, 0, 0, SLOTS);
        random_phase(445, 79, 0, 37);
        stretch_req = 1;
        random_phase(445, 0, 79, SLOTS);
        random_phase(445, 18, 18, 1);

        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("string_hash_table_open_addressing_tb: clean");
        end else begin
            $display("string_hash_table_open_addressing_tb: errors");
        end
        $finish;
    end

endmodule
